FILE: rtl/ctt_pkg.sv
package ctt_pkg;

  // Default longest atom in bytes
  localparam int unsigned MaxAtomLenDef = 512;

  // Entries in the queue between classifier and lexer
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Characters of interest
  localparam logic [7:0] ChHash   = 8'h23;  // '#'
  localparam logic [7:0] ChNl     = 8'h0a;  // '\n'
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChUscore = 8'h5f;  // '_'
  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChAt     = 8'h40;  // '@'
  localparam logic [7:0] ChDot    = 8'h2e;  // '.'
  localparam logic [7:0] ChDash   = 8'h2d;  // '-'
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;

  typedef enum logic [2:0] {
    ModeInit  = 3'd0,
    ModeNum   = 3'd1,
    ModeAtom  = 3'd2,
    ModeSq    = 3'd3,
    ModeDq    = 3'd4,
    ModeComm  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    EvNone  = 3'd0,
    EvAbyte = 3'd1,
    EvSbyte = 3'd2,
    EvAend  = 3'd3,
    EvSend  = 3'd4,
    EvInt   = 3'd5,
    EvErr   = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrUnknown = 2'd1,
    ErrAtom    = 2'd2,
    ErrNumber  = 2'd3
  } err_e;

  // One classified word as it travels through the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       digit;
    logic       atom_lead;
    logic       atom_body;
    logic       sep;      // space, tab or newline
    logic       nl;
    logic       hash;
    logic       squote;
    logic       dquote;
  } cls_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    logic alpha;
    alpha        = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    r.ch         = c;
    r.digit      = (c >= 8'h30) && (c <= 8'h39);
    r.atom_lead  = alpha || (c == ChUscore) || (c == ChDollar) || (c == ChAt);
    r.atom_body  = r.atom_lead || r.digit || (c == ChDot) || (c == ChDash);
    r.nl         = (c == ChNl);
    r.sep        = r.nl || (c == ChSpace) || (c == ChTab);
    r.hash       = (c == ChHash);
    r.squote     = (c == ChSquote);
    r.dquote     = (c == ChDquote);
    return r;
  endfunction

endpackage

FILE: rtl/ctt_fifo.sv
module ctt_fifo
  import ctt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_t      push_data_i,
  input  logic      pop_i,
  output cls_t      pop_data_o,
  output q_status_t status_o
);

  cls_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  localparam logic [QueuePtrW-1:0] PtrLast = QueuePtrW'(QueueDepth - 1);
  localparam logic [QueueCntW-1:0] CntFull = QueueCntW'(QueueDepth);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntFull);
  assign status_o.empty = (cnt_q == '0);

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntFull) && !pop_i |-> !push_i)
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue read while empty");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count out of range");

endmodule

FILE: rtl/ctt_front.sv
module ctt_front
  import ctt_pkg::*;
(
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [7:0] in_byte_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output cls_t      push_data_o
);

  // Stall only on a full queue, so the source never waits on the lexer directly
  assign in_stall_o  = q_status_i.full;
  assign push_o      = in_valid_i && !q_status_i.full;
  assign push_data_o = classify(in_byte_i);

endmodule

FILE: rtl/ctt_back.sv
module ctt_back
  import ctt_pkg::*;
#(
  parameter int unsigned MaxAtomLen = MaxAtomLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_status_t   q_status_i,
  input  cls_t        item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [63:0] number_value_o,
  output logic [15:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic [31:0] line_number_o,
  output logic        halted_o
);

  localparam logic [15:0] AtomLim = 16'(MaxAtomLen);

  mode_e       mode_q, mode_d;
  logic [63:0] acc_q, acc_d;
  logic [15:0] len_q, len_d;
  logic [31:0] line_q, line_d;
  logic        stop_q, stop_d;
  err_e        err_q, err_d;

  logic        out_valid_q;
  event_e      ev;
  err_e        err_now;
  logic [7:0]  data;
  logic [63:0] num;
  logic [15:0] tlen;
  logic [15:0] len_inc;
  logic [63:0] acc_next;

  logic [2:0]  ev_q;
  logic [7:0]  data_q;
  logic [63:0] num_q;
  logic [15:0] tlen_q;
  logic [1:0]  errc_q;
  logic [31:0] line_out_q;
  logic        halt_q;

  // Take a word whenever the output register is free or being emptied
  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  assign len_inc  = (len_q == 16'hffff) ? len_q : len_q + 16'd1;
  assign acc_next = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + {60'd0, item_i.ch[3:0]};

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    len_d   = len_q;
    line_d  = line_q;
    stop_d  = stop_q;
    err_d   = err_q;
    ev      = EvNone;
    err_now = ErrNone;
    data    = '0;
    num     = '0;
    tlen    = '0;
    if (pop_o && !stop_q) begin
      if (item_i.nl) begin
        line_d = line_q + 32'd1;
      end
      case (mode_q)
        ModeNum: begin
          if (item_i.digit) begin
            acc_d = acc_next;
          end else if (item_i.sep) begin
            ev     = EvInt;
            num    = acc_q;
            mode_d = ModeInit;
          end else begin
            err_now = ErrNumber;
          end
        end
        ModeSq, ModeDq: begin
          if ((mode_q == ModeSq && item_i.squote) || (mode_q == ModeDq && item_i.dquote)) begin
            ev     = EvSend;
            tlen   = len_q;
            mode_d = ModeInit;
          end else begin
            ev    = EvSbyte;
            data  = item_i.ch;
            len_d = len_inc;
          end
        end
        ModeAtom: begin
          if (item_i.sep) begin
            ev     = EvAend;
            tlen   = len_q;
            mode_d = ModeInit;
          end else if (item_i.atom_body && (len_q < AtomLim)) begin
            ev    = EvAbyte;
            data  = item_i.ch;
            len_d = len_inc;
          end else begin
            err_now = ErrAtom;
          end
        end
        ModeComm: begin
          if (item_i.nl) begin
            mode_d = ModeInit;
          end
        end
        default: begin
          if (item_i.hash) begin
            mode_d = ModeComm;
          end else if (item_i.atom_lead) begin
            mode_d = ModeAtom;
            len_d  = 16'd1;
            ev     = EvAbyte;
            data   = item_i.ch;
          end else if (item_i.squote) begin
            mode_d = ModeSq;
            len_d  = '0;
          end else if (item_i.dquote) begin
            mode_d = ModeDq;
            len_d  = '0;
          end else if (item_i.digit) begin
            mode_d = ModeNum;
            acc_d  = {60'd0, item_i.ch[3:0]};
          end else if (!item_i.sep) begin
            err_now = ErrUnknown;
          end
        end
      endcase
      if (err_now != ErrNone) begin
        // Freeze mode and token state; only the error is recorded
        mode_d = mode_q;
        acc_d  = acc_q;
        len_d  = len_q;
        err_d  = err_now;
        stop_d = 1'b1;
        ev     = EvErr;
        data   = '0;
        num    = '0;
        tlen   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeInit;
      acc_q       <= '0;
      len_q       <= '0;
      line_q      <= 32'd1;
      stop_q      <= 1'b0;
      err_q       <= ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      line_q      <= line_d;
      stop_q      <= stop_d;
      err_q       <= err_d;
      out_valid_q <= pop_o || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q       <= ev;
      data_q     <= data;
      num_q      <= num;
      tlen_q     <= tlen;
      errc_q     <= err_d;
      line_out_q <= line_d;
      halt_q     <= stop_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign data_byte_o    = data_q;
  assign number_value_o = num_q;
  assign token_length_o = tlen_q;
  assign error_code_o   = errc_q;
  assign line_number_o  = line_out_q;
  assign halted_o       = halt_q;

  a_stop_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q && $stable(err_q) && $stable(mode_q) && $stable(line_q))
    else $error("halt not sticky");

  a_stop_has_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q == (err_q != ErrNone))
    else $error("halt flag and error disagree");

  a_halt_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && halt_q |-> (errc_q != ErrNone) &&
      (ev_q == EvErr || ev_q == EvNone))
    else $error("halted word carries wrong event");

  a_atom_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeAtom |-> (len_q <= AtomLim) && (len_q != '0))
    else $error("atom length out of range");

endmodule

FILE: rtl/config_text_tokenizer_unit.sv
// Streaming tokenizer for a small configuration language. One text byte
// goes in per input word and exactly one result word comes out for it, in
// order. Atoms and strings are not buffered: each content byte comes out as
// an atom byte or string byte event, and an end event carries the length
// (saturating at 65535). Decimal integers accumulate modulo 2^64 and are
// reported when a space, tab or newline ends them; a token still open when
// the text stops is never reported. Lines count from one and every result
// before a halt shows the count after its own newline. The first error
// (unknown character, bad atom, bad number) is sticky: from then on each
// byte gives an empty result with halted set, until reset. Rate: one byte
// per clock sustained while the result sink does not stall; each result
// word passes through the classifier queue and is then registered at the
// output. The rate is set by the lexer's state update, whose longest path
// is the 64-bit multiply-by-ten-and-add of the integer accumulator.
module config_text_tokenizer_unit
  import ctt_pkg::*;
#(
  parameter int unsigned MaxAtomLen = MaxAtomLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [63:0] number_value_o,
  output logic [15:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic [31:0] line_number_o,
  output logic        halted_o
);

  q_status_t q_status;
  logic      push;
  cls_t      push_data;
  logic      pop;
  cls_t      pop_data;

  // Front: handshake and character classification
  ctt_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Short queue decouples the source from a stalled result sink
  ctt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Back: lexer state machine, counters and result register
  ctt_back #(
    .MaxAtomLen (MaxAtomLen)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .item_i         (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .data_byte_o    (data_byte_o),
    .number_value_o (number_value_o),
    .token_length_o (token_length_o),
    .error_code_o   (error_code_o),
    .line_number_o  (line_number_o),
    .halted_o       (halted_o)
  );

endmodule
